>>> sv/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> sv/bpfa_pkg.sv
// package for the bitmap page frame allocator
`default_nettype none
package bpfa_pkg;
    localparam int unsigned FRAME_COUNT_DEF = 131072;
    localparam int unsigned PAGE_BYTES_DEF  = 4096;
    localparam int unsigned WORD_BITS       = 64;

    typedef enum logic [2:0] {
        CMD_BEGIN_INIT  = 3'd0,
        CMD_ADD_REGION  = 3'd1,
        CMD_FINISH_INIT = 3'd2,
        CMD_ALLOC       = 3'd3,
        CMD_FREE        = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_CLAIM_RD,
        ST_CLAIM_WR,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

>>> sv/bpfa_ram.sv
// generic single port ram with registered read
`default_nettype none
module bpfa_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> sv/bitmap_page_frame_allocator.sv
// top level of the bitmap page frame allocator
// The frame map lives in one RAM, 64 frames a word. Every command is a
// transaction on start/busy and gives exactly one result, shown for one cycle
// with o_done; the receiver cannot stall it. Reset runs a fill pass writing
// all ones to every word with busy high and no result. Begin_init runs the
// same fill pass, then gives its result. Add_region (region type 1 only),
// finish_init and free read-modify-write each touched word, a read state and
// then a write state per word, then give the result. Alloc scans from frame 0
// up to the managed count: for each word a read state, then a check state for
// each group of eight frames, then claims the run with a read and a write per
// word it covers, then gives the result. All map work goes through the single
// RAM port, and the scan checks eight frames per check state.
`default_nettype none
`include "assert_macros.svh"
module bitmap_page_frame_allocator #(
    parameter int unsigned FRAME_COUNT = bpfa_pkg::FRAME_COUNT_DEF,
    parameter int unsigned PAGE_BYTES  = bpfa_pkg::PAGE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [29:0] i_cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_command,
    input  wire logic [47:0] i_base_address,
    input  wire logic [47:0] i_region_length,
    input  wire logic [7:0]  i_region_type,
    input  wire logic [17:0] i_page_count,
    output logic             o_done,
    output logic [28:0]      o_alloc_address,
    output logic             o_alloc_ok,
    output logic [17:0]      o_managed_frames
);
    import bpfa_pkg::*;

    localparam int unsigned WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    // holds FRAME_COUNT and a full page count
    localparam int unsigned FW    = ($clog2(FRAME_COUNT) + 1 > 18)
                                    ? $clog2(FRAME_COUNT) + 1 : 18;
    localparam int unsigned PSH   = $clog2(PAGE_BYTES);
    localparam int unsigned FRW   = 50;                      // wide frame number
    localparam int unsigned GRP_BITS = 8;                    // frames checked per cycle
    localparam int unsigned GRPS     = WORD_BITS / GRP_BITS;
    localparam int unsigned GW       = $clog2(GRPS);

    // state
    t_state r_state, n_state;
    logic [AW-1:0]      r_wa, n_wa;
    logic [FRW-1:0]     r_lo, n_lo;      // first frame of range, inclusive
    logic [FRW-1:0]     r_hi, n_hi;      // last frame, exclusive
    logic               r_setv, n_setv;  // value written into range
    logic [FW-1:0]      r_limit, n_limit;
    logic [29:0]        r_kend;
    logic [FW-1:0]      r_run, n_run;
    logic [FW-1:0]      r_start, n_start;
    logic [FW-1:0]      r_need, n_need;
    logic [GW-1:0]      r_grp, n_grp;
    logic               r_ok, n_ok;
    logic [28:0]        r_addr, n_addr;
    logic               r_fill_cmd;      // fill pass came from begin_init
    logic [WORD_BITS-1:0] w_rdata, w_wdata;
    logic               w_we;
    logic [AW-1:0]      w_ra;

    bpfa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_ra),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    // range arithmetic on input
    logic [48:0] w_end;
    logic [FRW-1:0] w_first_up, w_last_dn, w_fbase, w_fend, w_kend_up, w_cap;
    assign w_end      = {1'b0, i_base_address} + {1'b0, i_region_length};
    assign w_first_up = FRW'((49'(i_base_address) + 49'(PAGE_BYTES - 1)) >> PSH);
    assign w_last_dn  = FRW'(w_end >> PSH);
    assign w_fbase    = FRW'(i_base_address >> PSH);
    assign w_fend     = w_fbase + FRW'(i_page_count);
    assign w_kend_up  = FRW'((31'(r_kend) + 31'(PAGE_BYTES - 1)) >> PSH);
    assign w_cap      = FRW'(FRAME_COUNT);

    // word frame base and per-bit masks
    logic [FRW-1:0] w_wbase;
    logic [WORD_BITS-1:0] w_rmask;
    assign w_wbase = FRW'(r_wa) << $clog2(WORD_BITS);
    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_rmask[b] = ((w_wbase + FRW'(b)) >= r_lo) && ((w_wbase + FRW'(b)) < r_hi);
        end
    end

    // one eight-frame group of the current word per cycle
    logic [FRW-1:0] w_gbase, w_gend;
    logic [GRP_BITS-1:0] w_grp_bits;
    assign w_gbase    = w_wbase + (FRW'(r_grp) << $clog2(GRP_BITS));
    assign w_gend     = w_gbase + FRW'(GRP_BITS);
    assign w_grp_bits = w_rdata[r_grp * GRP_BITS +: GRP_BITS];

    // run and start carry across groups and words
    logic [FW-1:0] w_run_o, w_start_o;
    logic          w_hit;
    logic [FW-1:0] w_hit_start;
    always_comb begin
        logic [FW-1:0] run, st, fr;
        logic hit;
        run = r_run; st = r_start; hit = 1'b0; w_hit_start = r_start;
        for (int b = 0; b < GRP_BITS; b++) begin
            fr = FW'(w_gbase + FRW'(b));
            if (!hit && (FRW'(fr) < FRW'(r_limit)) && (FRW'(fr) < w_cap)) begin
                if (!w_grp_bits[b]) begin
                    if (run == '0) st = fr;
                    run = run + 1'b1;
                    if (run == r_need) begin
                        hit = 1'b1;
                        w_hit_start = st;
                    end
                end else begin
                    run = '0;
                end
            end
        end
        w_run_o = run; w_start_o = st; w_hit = hit;
    end

    logic [FRW-1:0] w_last_word_f;
    assign w_last_word_f = w_wbase + FRW'(WORD_BITS);

    always_comb begin
        n_state = r_state;
        n_wa = r_wa; n_lo = r_lo; n_hi = r_hi; n_setv = r_setv;
        n_limit = r_limit; n_run = r_run; n_start = r_start; n_need = r_need;
        n_grp = r_grp;
        n_ok = r_ok; n_addr = r_addr;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_ok = 1'b0; n_addr = '0; n_wa = '0;
                    case (t_cmd'(i_command))
                        CMD_BEGIN_INIT: begin
                            n_limit = '0;
                            n_state = ST_FILL;
                        end
                        CMD_ADD_REGION: begin
                            if (i_region_type == 8'd1) begin
                                n_lo = w_first_up;
                                n_hi = (w_last_dn > w_cap) ? w_cap : w_last_dn;
                                if (FW'(n_hi) > r_limit) n_limit = FW'(n_hi);
                                n_setv = 1'b0;
                                n_wa = AW'(w_first_up >> $clog2(WORD_BITS));
                                n_state = (w_first_up < n_hi) ? ST_MARK_RD : ST_DONE;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end
                        CMD_FINISH_INIT: begin
                            n_lo = '0;
                            n_hi = (w_kend_up > w_cap) ? w_cap : w_kend_up;
                            n_setv = 1'b1;
                            n_state = (n_hi != '0) ? ST_MARK_RD : ST_DONE;
                        end
                        CMD_ALLOC: begin
                            n_need = FW'(i_page_count);
                            n_run = '0; n_start = '0; n_grp = '0;
                            n_state = (i_page_count != '0 && r_limit != '0)
                                      ? ST_SCAN_RD : ST_DONE;
                        end
                        CMD_FREE: begin
                            n_lo = w_fbase;
                            n_hi = (w_fend > w_cap) ? w_cap : w_fend;
                            n_setv = 1'b0;
                            n_wa = AW'(w_fbase >> $clog2(WORD_BITS));
                            n_state = (w_fbase < n_hi) ? ST_MARK_RD : ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_FILL: begin
                n_wa = r_wa + 1'b1;
                // fill after reset ends without a result
                if (r_wa == AW'(WORDS - 1)) n_state = r_fill_cmd ? ST_DONE : ST_IDLE;
            end
            ST_MARK_RD: n_state = ST_MARK_WR;
            ST_MARK_WR: begin
                n_wa = r_wa + 1'b1;
                if (w_last_word_f >= r_hi || r_wa == AW'(WORDS - 1)) n_state = ST_DONE;
                else n_state = ST_MARK_RD;
            end
            ST_SCAN_RD: n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                n_run = w_run_o; n_start = w_start_o;
                if (w_hit) begin
                    n_ok = 1'b1;
                    n_addr = 29'(FRW'(w_hit_start) << PSH);
                    n_lo = FRW'(w_hit_start);
                    n_hi = FRW'(w_hit_start) + FRW'(r_need);
                    n_setv = 1'b1;
                    n_wa = AW'(w_hit_start >> $clog2(WORD_BITS));
                    n_state = ST_MARK_RD;
                end else if (w_gend >= FRW'(r_limit) ||
                             (r_grp == GW'(GRPS - 1) && r_wa == AW'(WORDS - 1))) begin
                    n_state = ST_DONE;
                end else if (r_grp == GW'(GRPS - 1)) begin
                    n_grp = '0;
                    n_wa = r_wa + 1'b1;
                    n_state = ST_SCAN_RD;
                end else begin
                    n_grp = r_grp + 1'b1;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // memory port and outputs
    always_comb begin
        w_ra = r_wa;
        w_we = 1'b0;
        w_wdata = w_rdata;
        case (r_state)
            ST_FILL: begin
                w_we = 1'b1;
                w_wdata = '1;
            end
            ST_MARK_WR: begin
                w_we = 1'b1;
                w_wdata = r_setv ? (w_rdata | w_rmask) : (w_rdata & ~w_rmask);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
        busy = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
        o_alloc_address = r_addr;
        o_alloc_ok = r_ok;
        o_managed_frames = 18'(r_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_wa <= '0;
            r_limit <= '0;
            r_kend <= '0;
            r_ok <= 1'b0;
            r_addr <= '0;
        end else begin
            r_state <= n_state;
            r_wa <= n_wa;
            r_limit <= n_limit;
            r_ok <= n_ok;
            r_addr <= n_addr;
            if (i_cfg_we) r_kend <= i_cfg_wdata;
        end
    end

    // fill after reset ends without a result; begin_init fill gives one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_fill_cmd <= 1'b0;
        else if (r_state == ST_IDLE && start) r_fill_cmd <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo; r_hi <= n_hi; r_setv <= n_setv;
        r_run <= n_run; r_start <= n_start; r_need <= n_need;
        r_grp <= n_grp;
    end

    `ASSERT_IMPLIES(a_done_busy, i_clk, i_rst_n, o_done, busy)
    `ASSERT_IMPLIES(a_ok_addr, i_clk, i_rst_n, o_done && !o_alloc_ok, o_alloc_address == '0)
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy)
endmodule
`default_nettype wire
